// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/pldcd_pkg.sv =====
// ---------------------------------------------------------------------------
// pldcd_pkg
// Types, codes and helper functions of the P6 dominant-channel dimmer.
// ---------------------------------------------------------------------------
package pldcd_pkg;

    // Default pixel capacity of the image store
    localparam int unsigned MAX_PIXELS_DEF = 65536;

    // Header parse phases
    localparam logic [2:0] PH_P      = 3'd0;
    localparam logic [2:0] PH_SIX    = 3'd1;
    localparam logic [2:0] PH_THIRD  = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_WIDTH  = 3'd4;
    localparam logic [2:0] PH_HEIGHT = 3'd5;
    localparam logic [2:0] PH_MAXVAL = 3'd6;
    localparam logic [2:0] PH_PIXELS = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_PIXEL  = 2'd0;
    localparam logic [1:0] ST_ERROR  = 2'd1;
    localparam logic [1:0] ST_LOADED = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // Channel dimming factors
    localparam logic [1:0] FACT_NONE   = 2'd0;
    localparam logic [1:0] FACT_SECOND = 2'd1;
    localparam logic [1:0] FACT_TOP    = 2'd2;

    // Character codes
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_6  = 8'h36;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;

    // Input request
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } pldcd_in_t;

    // Result
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last_pixel;
    } pldcd_out_t;

    // Classified request, front to back
    typedef struct packed {
        logic       is_read;
        logic       is_digit;
        logic [7:0] data_byte;
    } pldcd_cmd_t;

    // floor(10v/11) or floor(20v/21) by reciprocal multiply
    function automatic logic [7:0] scale_chan(input logic [7:0] v, input logic [1:0] f);
        logic [12:0] x10;
        logic [12:0] x20;
        logic [25:0] p11;
        logic [25:0] p21;
        logic [7:0]  res;
        x10 = 13'(v) * 13'd10;
        x20 = 13'(v) * 13'd20;
        p11 = 26'(x10) * 26'd5958;
        p21 = 26'(x20) * 26'd3121;
        case (f)
            FACT_TOP:    res = p11[23:16];
            FACT_SECOND: res = p21[23:16];
            default:     res = v;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/pldcd_front.sv =====
// ---------------------------------------------------------------------------
// pldcd_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module pldcd_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  pldcd_pkg::pldcd_in_t  item,
    output logic                  cmd_valid,
    output pldcd_pkg::pldcd_cmd_t cmd,
    input  logic                  cmd_take
);
    import pldcd_pkg::*;

    pldcd_cmd_t q_reg [2];
    pldcd_cmd_t q_in;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    // Classify the incoming request
    always_comb
    begin
        q_in.is_read   = item.cmd;
        q_in.is_digit  = (item.data_byte >= CH_0) && (item.data_byte <= CH_9);
        q_in.data_byte = item.data_byte;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= q_in;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/pldcd_div.sv =====
// ---------------------------------------------------------------------------
// pldcd_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pldcd_div
#(
    parameter int unsigned DW = 25,
    parameter int unsigned VW = 17
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int unsigned CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/pldcd_engine.sv =====
// ---------------------------------------------------------------------------
// pldcd_engine
// Back end: header parse, pixel store, channel means, ranking and readout.
// ---------------------------------------------------------------------------
module pldcd_engine
#(
    parameter int unsigned MAX_PIXELS = pldcd_pkg::MAX_PIXELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  pldcd_pkg::pldcd_cmd_t cmd,
    output logic                  cmd_take,
    input  logic                  pop,
    output logic                  empty,
    output pldcd_pkg::pldcd_out_t result
);
    import pldcd_pkg::*;

    localparam int unsigned AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned PIX_W = $clog2(MAX_PIXELS + 1);
    localparam int unsigned SUM_W = PIX_W + 8;

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_READ = 2'd1;
    localparam logic [1:0] E_DIV  = 2'd2;
    localparam logic [1:0] E_RANK = 2'd3;

    // Control and image state
    logic [1:0]       state_reg,   state_next;
    logic [2:0]       phase_reg,   phase_next;
    logic [15:0]      width_reg,   width_next;
    logic [15:0]      height_reg,  height_next;
    logic [1:0]       chan_reg,    chan_next;
    logic [PIX_W-1:0] wr_idx_reg,  wr_idx_next;
    logic [PIX_W-1:0] rd_idx_reg,  rd_idx_next;
    logic [PIX_W-1:0] total_reg,   total_next;
    logic [SUM_W-1:0] sum_reg  [3];
    logic [SUM_W-1:0] sum_next [3];
    logic [1:0]       fact_reg  [3];
    logic [1:0]       fact_next [3];
    logic [7:0]       mean_reg  [3];
    logic [7:0]       mean_next [3];
    logic [1:0]       dch_reg,     dch_next;
    logic             last_reg,    last_next;
    logic [7:0]       rhold_reg,   rhold_next;
    logic [7:0]       ghold_reg,   ghold_next;

    // Output buffer
    pldcd_out_t       out_reg;
    logic             out_valid_reg;
    logic             emit;
    pldcd_out_t       emit_data;
    logic             out_free;
    logic             take;

    // Pixel store
    logic [23:0]      mem [MAX_PIXELS];
    logic [23:0]      rd_data_reg;
    logic             mem_we;
    logic [23:0]      mem_wdata;
    logic             rd_en;

    // Divider
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_q;

    // Parse helpers
    logic [19:0]      dig_w;
    logic [19:0]      dig_h;
    logic [31:0]      area;
    logic [PIX_W:0]   wr_inc;

    // Ranking helpers
    logic [7:0]       first;
    logic [7:0]       second;

    pldcd_div
    #(
        .DW (SUM_W),
        .VW (PIX_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[dch_next]),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !out_valid_reg || pop;
    assign take     = (state_reg == E_IDLE) && cmd_valid && out_free;
    assign cmd_take = take;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // Datapath helpers
    always_comb
    begin
        dig_w  = 20'(width_reg) * 20'd10 + 20'(cmd.data_byte[3:0]);
        dig_h  = 20'(height_reg) * 20'd10 + 20'(cmd.data_byte[3:0]);
        area   = 32'(width_reg) * 32'(height_reg);
        wr_inc = (PIX_W + 1)'(wr_idx_reg) + (PIX_W + 1)'(1);
    end

    // Rank the channel means
    always_comb
    begin
        if (mean_reg[0] > mean_reg[1])
        begin
            if (mean_reg[0] > mean_reg[2])
            begin
                first  = mean_reg[0];
                second = (mean_reg[2] > mean_reg[1]) ? mean_reg[2] : mean_reg[1];
            end
            else
            begin
                first  = mean_reg[2];
                second = mean_reg[0];
            end
        end
        else
        begin
            if (mean_reg[1] > mean_reg[2])
            begin
                first  = mean_reg[1];
                second = (mean_reg[2] > mean_reg[0]) ? mean_reg[2] : mean_reg[0];
            end
            else
            begin
                first  = mean_reg[2];
                second = mean_reg[1];
            end
        end
    end

    // Main sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        width_next  = width_reg;
        height_next = height_reg;
        chan_next   = chan_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        total_next  = total_reg;
        dch_next    = dch_reg;
        last_next   = last_reg;
        rhold_next  = rhold_reg;
        ghold_next  = ghold_reg;
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k]  = sum_reg[k];
            fact_next[k] = fact_reg[k];
            mean_next[k] = mean_reg[k];
        end
        emit      = 1'b0;
        emit_data = '0;
        mem_we    = 1'b0;
        mem_wdata = {rhold_reg, ghold_reg, cmd.data_byte};
        rd_en     = 1'b0;
        div_start = 1'b0;

        case (state_reg)
            E_IDLE:
            begin
                if (take)
                begin
                    if (cmd.is_read)
                    begin
                        // Read request: issue a store read or answer empty
                        if ((phase_reg == PH_P) && (rd_idx_reg < wr_idx_reg))
                        begin
                            rd_en       = 1'b1;
                            last_next   = ((PIX_W + 1)'(rd_idx_reg) + (PIX_W + 1)'(1))
                                          == {1'b0, wr_idx_reg};
                            rd_idx_next = rd_idx_reg + PIX_W'(1);
                            state_next  = E_READ;
                        end
                        else
                        begin
                            emit             = 1'b1;
                            emit_data.status = ST_EMPTY;
                        end
                    end
                    else
                    begin
                        // File byte
                        logic fail;
                        logic clear;
                        fail  = 1'b0;
                        clear = 1'b0;
                        case (phase_reg)
                            PH_P:
                            begin
                                if (cmd.data_byte != CH_P)
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    clear      = 1'b1;
                                    phase_next = PH_SIX;
                                end
                            end
                            PH_SIX:
                            begin
                                if (cmd.data_byte != CH_6)
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_THIRD;
                                end
                            end
                            PH_THIRD:
                            begin
                                phase_next = (cmd.data_byte == CH_CR) ? PH_SKIP : PH_WIDTH;
                            end
                            PH_SKIP:
                            begin
                                phase_next = PH_WIDTH;
                            end
                            PH_WIDTH:
                            begin
                                if (cmd.data_byte == CH_SP)
                                begin
                                    phase_next = PH_HEIGHT;
                                end
                                else if (!cmd.is_digit || (dig_w[19:16] != 4'd0))
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    width_next = dig_w[15:0];
                                end
                            end
                            PH_HEIGHT:
                            begin
                                if (cmd.data_byte == CH_LF)
                                begin
                                    if ((area == 32'd0) || (area > 32'(MAX_PIXELS)))
                                    begin
                                        fail = 1'b1;
                                    end
                                    else
                                    begin
                                        total_next = area[PIX_W-1:0];
                                        phase_next = PH_MAXVAL;
                                    end
                                end
                                else if (!cmd.is_digit || (dig_h[19:16] != 4'd0))
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    height_next = dig_h[15:0];
                                end
                            end
                            PH_MAXVAL:
                            begin
                                if (cmd.data_byte == CH_LF)
                                begin
                                    phase_next = PH_PIXELS;
                                end
                            end
                            default:
                            begin
                                // Pixel byte: accumulate and store whole pixels
                                sum_next[chan_reg] = sum_reg[chan_reg] + SUM_W'(cmd.data_byte);
                                case (chan_reg)
                                    2'd0:
                                    begin
                                        rhold_next = cmd.data_byte;
                                        chan_next  = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        ghold_next = cmd.data_byte;
                                        chan_next  = 2'd2;
                                    end
                                    default:
                                    begin
                                        mem_we      = 1'b1;
                                        chan_next   = 2'd0;
                                        wr_idx_next = wr_inc[PIX_W-1:0];
                                        if (wr_inc >= {1'b0, total_reg})
                                        begin
                                            dch_next   = 2'd0;
                                            div_start  = 1'b1;
                                            state_next = E_DIV;
                                        end
                                    end
                                endcase
                            end
                        endcase

                        if (fail)
                        begin
                            clear            = 1'b1;
                            phase_next       = PH_P;
                            emit             = 1'b1;
                            emit_data.status = ST_ERROR;
                        end
                        if (clear)
                        begin
                            width_next  = '0;
                            height_next = '0;
                            chan_next   = '0;
                            wr_idx_next = '0;
                            rd_idx_next = '0;
                            total_next  = '0;
                            for (int k = 0; k < 3; k++)
                            begin
                                sum_next[k]  = '0;
                                fact_next[k] = FACT_NONE;
                            end
                        end
                    end
                end
            end
            E_READ:
            begin
                // Store data is back: scale and emit
                emit                 = 1'b1;
                emit_data.status     = ST_PIXEL;
                emit_data.red        = scale_chan(rd_data_reg[23:16], fact_reg[0]);
                emit_data.green      = scale_chan(rd_data_reg[15:8], fact_reg[1]);
                emit_data.blue       = scale_chan(rd_data_reg[7:0], fact_reg[2]);
                emit_data.last_pixel = last_reg;
                state_next           = E_IDLE;
            end
            E_DIV:
            begin
                // Channel means, one division after another
                if (div_done)
                begin
                    mean_next[dch_reg] = div_q[7:0];
                    if (dch_reg == 2'd2)
                    begin
                        state_next = E_RANK;
                    end
                    else
                    begin
                        dch_next  = dch_reg + 2'd1;
                        div_start = 1'b1;
                    end
                end
            end
            default:
            begin
                // Assign factors and report the loaded image
                for (int k = 0; k < 3; k++)
                begin
                    if (second == first)
                    begin
                        fact_next[k] = (mean_reg[k] == first) ? FACT_SECOND : FACT_NONE;
                    end
                    else if (mean_reg[k] == first)
                    begin
                        fact_next[k] = FACT_TOP;
                    end
                    else if (mean_reg[k] == second)
                    begin
                        fact_next[k] = FACT_SECOND;
                    end
                    else
                    begin
                        fact_next[k] = FACT_NONE;
                    end
                end
                emit                   = 1'b1;
                emit_data.status       = ST_LOADED;
                emit_data.image_width  = width_reg;
                emit_data.image_height = height_reg;
                rd_idx_next            = '0;
                phase_next             = PH_P;
                state_next             = E_IDLE;
            end
        endcase
    end

    // Pixel store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx_reg[AW-1:0]] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rhold_reg <= rhold_next;
        ghold_reg <= ghold_next;
        last_reg  <= last_next;
        for (int k = 0; k < 3; k++)
        begin
            mean_reg[k] <= mean_next[k];
        end
        if (emit)
        begin
            out_reg <= emit_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            phase_reg     <= PH_P;
            width_reg     <= '0;
            height_reg    <= '0;
            chan_reg      <= '0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            total_reg     <= '0;
            dch_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= '0;
                fact_reg[k] <= FACT_NONE;
            end
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            chan_reg   <= chan_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            total_reg  <= total_next;
            dch_reg    <= dch_next;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= sum_next[k];
                fact_reg[k] <= fact_next[k];
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/ppm_load_dominant_channel_dim.sv =====
// ---------------------------------------------------------------------------
// ppm_load_dominant_channel_dim
// Loads a binary P6 image from a byte stream and reads it back with the
// dominant color channel dimmed.
// ---------------------------------------------------------------------------
// Push one request per cycle into a two-entry input queue while it is not
// full; the back end works through them one at a time. A pixel read goes
// through the store's registered read port. After the last pixel byte the
// three channel means are formed by one shared bit-serial divider, then
// ranked, before the "image loaded" result appears. Every request except a
// silent header or pixel byte yields exactly one result in the output
// register; a request is only started while that register is free or being
// popped. No clearing pass is needed after reset.
module ppm_load_dominant_channel_dim
#(
    parameter int unsigned MAX_PIXELS = pldcd_pkg::MAX_PIXELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  pldcd_pkg::pldcd_in_t  item,
    output logic                  empty,
    input  logic                  pop,
    output pldcd_pkg::pldcd_out_t result
);
    import pldcd_pkg::*;

    logic       cmd_valid;
    pldcd_cmd_t cmd;
    logic       cmd_take;

    pldcd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    pldcd_engine
    #(
        .MAX_PIXELS (MAX_PIXELS)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// ===== rtl/pldcd_checker.sv =====
// ---------------------------------------------------------------------------
// pldcd_checker
// Port-level checks on the result side of the dimmer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pldcd_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  empty,
    input logic                  pop,
    input pldcd_pkg::pldcd_out_t result
);
    import pldcd_pkg::*;

    // Only pixel results carry color or the last-pixel mark
    `AST_IMPLY(a_color_zero, clk, rst_n, !empty && (result.status != ST_PIXEL), (result.red == 8'd0) && (result.green == 8'd0) && (result.blue == 8'd0) && !result.last_pixel)

    // Only the loaded result carries the image size
    `AST_IMPLY(a_size_zero, clk, rst_n, !empty && (result.status != ST_LOADED), (result.image_width == 16'd0) && (result.image_height == 16'd0))

    // A loaded image is never reported with a zero dimension
    `AST_IMPLY(a_size_nonzero, clk, rst_n, !empty && (result.status == ST_LOADED), (result.image_width != 16'd0) && (result.image_height != 16'd0))

    // A waiting result holds until taken
    `AST_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(result))

endmodule

bind ppm_load_dominant_channel_dim pldcd_checker u_pldcd_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
